/* hdl/ttlmc_pkg.sv */
// ----------------------------------------------------------------------------
// ttlmc_pkg
// Shared types and constants for the TTL membership cache.
// ----------------------------------------------------------------------------
`default_nettype none
package ttlmc_pkg;
  localparam int ENTRIES_DEF = 256;
  localparam int KEY_W       = 1 + 128 + 256;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic CFG_TTL   = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic rd;       // read slot at scan index
    logic chk;      // evaluate slot read last cycle
    logic wr;       // store into slot
    logic tick;
    logic clr;      // table clear
  } ttlmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic last;     // scan index at final slot
  } ttlmc_sts_t;
endpackage
`default_nettype wire

/* hdl/ttlmc_datapath.sv */
// ----------------------------------------------------------------------------
// ttlmc_datapath
// Slot memory, valid bits, seconds counter, pointer and scan compare.
// ----------------------------------------------------------------------------
`default_nettype none
module ttlmc_datapath import ttlmc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ttlmc_cmd_t   cmd,
  output ttlmc_sts_t        sts,
  input  wire logic [1:0]   family,
  input  wire logic [63:0]  addr_high,
  input  wire logic [63:0]  addr_low,
  input  wire logic [255:0] name_in,
  input  wire logic         member_in,
  input  wire logic [11:0]  ttl,
  input  wire logic [8:0]   count_cfg,
  output logic              member_out
);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [32:0]      aux_mem [ENTRIES];  // {member, expiry}
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, rkey_r;
  logic [32:0]      raux_r;
  logic [IW-1:0]    idx_r, ridx_r, ptr_r, ptr_nxt;
  logic [31:0]      now_r;
  logic             member_r;
  logic             mem_r;      // member bit of the captured store
  logic [CW-1:0]    cnt;
  logic [255:0]     clean;
  logic             ended;
  logic [32:0]      exp_sum;
  logic [IW-1:0]    wslot;

  // effective slot count: 0 -> 1, clamp to ENTRIES
  always_comb begin
    if (count_cfg == 9'd0) cnt = CW'(1);
    else if (32'(count_cfg) > 32'(ENTRIES)) cnt = CW'(ENTRIES);
    else cnt = CW'(count_cfg);
  end

  // name ends at first zero byte; byte 31 forced zero
  always_comb begin
    clean = '0;
    ended = 1'b0;
    for (int k = 0; k < 32; k++) begin
      if (!(ended || k == 31)) clean[8*k +: 8] = name_in[8*k +: 8];
      if (ended || k == 31 || name_in[8*k +: 8] == 8'd0) ended = 1'b1;
    end
  end

  assign exp_sum = {1'b0, now_r} + 33'(ttl);
  assign sts.last = ({{(32-IW){1'b0}}, idx_r} + 32'd1) >= 32'(cnt);
  assign sts.hit  = cmd.chk && valid_r[ridx_r] && (raux_r[31:0] > now_r)
                    && (rkey_r == key_r);
  assign member_out = member_r;
  assign wslot = ({{(32-IW){1'b0}}, ptr_r} >= 32'(cnt)) ? '0 : ptr_r;

  always_comb begin
    valid_nxt = valid_r;
    ptr_nxt   = ptr_r;
    if (cmd.chk && valid_r[ridx_r] && raux_r[31:0] <= now_r)
      valid_nxt[ridx_r] = 1'b0;
    if (cmd.wr) begin
      valid_nxt[wslot] = 1'b1;
    end
    if (cmd.wr) begin
      if ({{(32-IW){1'b0}}, ptr_r} >= 32'(cnt)) ptr_nxt = '0;
      if (({{(32-IW){1'b0}}, ptr_nxt} + 32'd1) >= 32'(cnt)) ptr_nxt = '0;
      else ptr_nxt = ptr_nxt + IW'(1);
    end
    if (cmd.clr) begin
      valid_nxt = '0;
      ptr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
      now_r   <= '0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
      if (cmd.tick && now_r != 32'hFFFF_FFFF) now_r <= now_r + 32'd1;
      if (cmd.load) idx_r <= '0;
      else if (cmd.rd) idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= {family[0], (family[0] ? addr_high : 64'd0),
                (family[0] ? addr_low : {32'd0, addr_low[31:0]}), clean};
      mem_r    <= member_in;
      member_r <= 1'b0;
    end
    if (cmd.rd) begin
      rkey_r <= key_mem[idx_r];
      raux_r <= aux_mem[idx_r];
      ridx_r <= idx_r;
    end
    if (sts.hit) member_r <= raux_r[32];
    if (cmd.wr) begin
      key_mem[wslot] <= key_r;
      aux_mem[wslot] <= {mem_r, exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0]};
    end
  end
endmodule
`default_nettype wire

/* hdl/ttlmc_ctrl.sv */
// ----------------------------------------------------------------------------
// ttlmc_ctrl
// Request sequencer: decode, slot scan, store, result hold.
// ----------------------------------------------------------------------------
`default_nettype none
module ttlmc_ctrl import ttlmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [1:0] req_type,
  input  wire logic [1:0] family,
  input  wire logic [11:0] ttl,
  input  wire logic       cfg_clr,
  input  wire ttlmc_sts_t sts,
  output ttlmc_cmd_t      cmd,
  output logic            busy,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CHK = 3'd2,
                         S_WR = 3'd3, S_OUT = 3'd4;
  logic [2:0] state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       lastrd_r;

  assign busy = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign status = status_r;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd = '0;
    cmd.clr = cfg_clr;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        if (req_type == REQ_TICK) begin
          cmd.tick = 1'b1; status_nxt = ST_DONE; state_nxt = S_OUT;
        end else if (req_type == REQ_LOOKUP || req_type == REQ_STORE) begin
          if (family[1]) begin
            status_nxt = ST_BAD; state_nxt = S_OUT;
          end else if (req_type == REQ_LOOKUP) begin
            status_nxt = ST_MISS;
            state_nxt = (ttl == 12'd0) ? S_OUT : S_RD;
          end else begin
            status_nxt = ST_DONE;
            state_nxt = (ttl == 12'd0) ? S_OUT : S_WR;
          end
        end else begin
          status_nxt = ST_DONE; state_nxt = S_OUT;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1; state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.hit) begin
          status_nxt = ST_HIT; state_nxt = S_OUT;
        end else if (lastrd_r) state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_WR: begin
        cmd.wr = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DONE;
      lastrd_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (cmd.rd) lastrd_r <= sts.last;
    end
  end
endmodule
`default_nettype wire

/* hdl/ttl_membership_cache_unit.sv */
// Accept to out_tvalid: a lookup reads then checks each slot in turn until a
//   hit or the last active slot; a store writes one slot; tick, bad family,
//   disabled cache and unused type go straight to the result. Throughput: one
//   item at a time; the next item is taken the cycle after the result leaves.
//   The scan reads a slot in one state and checks it in the next.
// Reset (rst_n, sync): table empty, pointer 0, seconds 0, ttl 5, count 256.
// ----------------------------------------------------------------------------
// ttl_membership_cache_unit
// Fully associative TTL cache of address-in-set answers, round-robin fill.
// ----------------------------------------------------------------------------
`default_nettype none
module ttl_membership_cache_unit import ttlmc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [1:0] req_type, [3:2] family, [67:4] addr_high, [131:68] addr_low,
  // [195:132] name_word0 .. [387:324] name_word3, [388] member_in, pad
  input  wire logic [391:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [1:0] status, [2] member_out, pad
  output logic [7:0]        out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [11:0]  cfg_data
);
  logic [11:0] ttl_r;
  logic [8:0]  count_r;
  logic        busy, in_fire, cfg_fire, cfg_clr, member;
  logic [1:0]  status;
  ttlmc_cmd_t  cmd;
  ttlmc_sts_t  sts;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_clr   = cfg_fire && cfg_index == CFG_COUNT;
  assign out_tdata = {5'd0, member, status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r   <= 12'd5;
      count_r <= 9'd256;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_TTL) ttl_r <= cfg_data;
      else count_r <= cfg_data[8:0];
    end
  end

  ttlmc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .req_type(in_tdata[1:0]), .family(in_tdata[3:2]), .ttl(ttl_r),
    .cfg_clr, .sts, .cmd, .busy,
    .out_valid(out_tvalid), .out_ready(out_tready), .status
  );

  ttlmc_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .family(in_tdata[3:2]), .addr_high(in_tdata[67:4]),
    .addr_low(in_tdata[131:68]), .name_in(in_tdata[387:132]),
    .member_in(in_tdata[388]), .ttl(ttl_r), .count_cfg(count_r),
    .member_out(member)
  );
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TTL membership cache: a directed table, then
// random lookups, stores and ticks on a small key pool, checked item by item
// against a behavioral model of the slot table.
// ----------------------------------------------------------------------------
`default_nettype none
module tb import ttlmc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 256;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [391:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [11:0]  cfg_data = '0;

  ttl_membership_cache_unit dut (.*);

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  fam;
    logic [63:0] ahi, alo;
    logic [255:0] name;
    logic        mem;
  } req_item_t;

  typedef struct {
    logic [1:0] status;
    logic       member;
  } answer_t;

  // model state
  logic         m_valid [NSLOT];
  logic         m_fam   [NSLOT];
  logic [127:0] m_addr  [NSLOT];
  logic [255:0] m_name  [NSLOT];
  logic         m_mem   [NSLOT];
  logic [31:0]  m_exp   [NSLOT];
  logic [31:0]  m_now;
  int           m_ptr;
  logic [11:0]  m_ttl;
  logic [8:0]   m_count;

  answer_t pending_answers[$];
  int      errors = 0;
  int      items_sent = 0, answers_seen = 0, hits_seen = 0;
  bit      hold_off = 1'b0;
  longint  cycles = 0;

  function automatic logic [255:0] trim_name(logic [255:0] n);
    logic [255:0] r;
    bit ended;
    r = '0;
    ended = 0;
    for (int k = 0; k < 32; k++) begin
      logic [7:0] b;
      b = n[8*k +: 8];
      if (k == 31 || ended) b = 8'd0;
      if (b == 8'd0) ended = 1;
      r[8*k +: 8] = b;
    end
    return r;
  endfunction

  function automatic int slots_active();
    if (m_count == 0) return 1;
    if (m_count > NSLOT) return NSLOT;
    return m_count;
  endfunction

  function automatic void cache_clear();
    foreach (m_valid[i]) m_valid[i] = 1'b0;
    m_ptr = 0;
  endfunction

  // Runs one item through the model, returns its answer.
  function automatic answer_t cache_answer(req_item_t r);
    answer_t a;
    logic [127:0] addr;
    logic [255:0] nm;
    longint unsigned ex;
    int cnt, s;
    a.status = ST_DONE;
    a.member = 1'b0;
    cnt = slots_active();
    if (r.req == REQ_TICK) begin
      if (m_now != 32'hFFFF_FFFF) m_now++;
    end else if (r.req == REQ_LOOKUP || r.req == REQ_STORE) begin
      if (r.fam > 2'd1) begin
        a.status = ST_BAD;
      end else begin
        addr = (r.fam == 2'd0) ? {64'd0, 32'd0, r.alo[31:0]} : {r.ahi, r.alo};
        nm = trim_name(r.name);
        if (r.req == REQ_LOOKUP) begin
          a.status = ST_MISS;
          if (m_ttl != 0) begin
            for (int i = 0; i < cnt; i++) begin
              if (!m_valid[i]) continue;
              if (m_exp[i] <= m_now) begin
                m_valid[i] = 1'b0;
                continue;
              end
              if (m_fam[i] == r.fam[0] && m_addr[i] == addr && m_name[i] == nm) begin
                a.status = ST_HIT;
                a.member = m_mem[i];
                break;
              end
            end
          end
        end else if (m_ttl != 0) begin
          s = (m_ptr >= cnt) ? 0 : m_ptr;
          ex = longint'(m_now) + m_ttl;
          m_valid[s] = 1'b1;
          m_fam[s]   = r.fam[0];
          m_addr[s]  = addr;
          m_name[s]  = nm;
          m_mem[s]   = r.mem;
          m_exp[s]   = (ex > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ex[31:0];
          m_ptr      = (s + 1 >= cnt) ? 0 : s + 1;
        end
      end
    end
    return a;
  endfunction

  // small key pool so lookups find stored keys
  logic [63:0]  pool_ahi [8];
  logic [63:0]  pool_alo [8];
  logic [255:0] pool_name [4];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_item_t random_item();
    req_item_t r;
    int p;
    p = $urandom_range(0, 99);
    r.ahi  = pool_ahi[$urandom_range(0, 7)];
    r.alo  = pool_alo[$urandom_range(0, 7)];
    r.name = pool_name[$urandom_range(0, 3)];
    r.fam  = 2'($urandom_range(0, 1));
    r.mem  = 1'($urandom_range(0, 1));
    if (p < 45) r.req = REQ_LOOKUP;
    else if (p < 80) r.req = REQ_STORE;
    else if (p < 92) r.req = REQ_TICK;
    else begin
      // noise: full random fields, odd families, unused request type
      r.req  = 2'($urandom_range(0, 3));
      r.fam  = 2'($urandom_range(0, 3));
      r.ahi  = rand64();
      r.alo  = rand64();
      r.name = {rand64(), rand64(), rand64(), rand64()};
    end
    return r;
  endfunction

  // --- sender side --------------------------------------------------------
  // tvalid stays up between back-to-back items; it drops only for a gap or at the end of a run
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic release_in();
    in_tvalid <= 1'b0;
  endtask

  task automatic send_item(req_item_t r, bit checked_by_hand, answer_t hand);
    answer_t a;
    a = cache_answer(r);
    if (checked_by_hand && (a.status != hand.status || a.member != hand.member))
      $display("note: table row disagrees with model, req %0d", r.req);
    pending_answers.push_back(checked_by_hand ? hand : a);
    in_tdata  <= {3'b0, r.mem, r.name, r.alo, r.ahi, r.fam, r.req};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TTL) m_ttl = val;
    else begin
      m_count = val[8:0];
      cache_clear();
    end
  endtask

  // Drain outstanding answers, then wait out any trailing work.
  task automatic settle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // --- receiver side ------------------------------------------------------
  always @(posedge clk) begin
    int g;
    if (rst_n) begin
      if (hold_off) out_tready <= 1'b0;
      else begin
        g = $urandom_range(0, 19);
        out_tready <= (g < 14) ? 1'b1 : (g < 19) ? 1'b0 : ($urandom_range(0, 1) == 1);
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected answer %h", out_tdata);
      end else begin
        want = pending_answers.pop_front();
        if (want.status == ST_HIT) hits_seen++;
        if (out_tdata[1:0] !== want.status || out_tdata[2] !== want.member) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d member %0d, got status %0d member %0d",
                     want.status, want.member, out_tdata[1:0], out_tdata[2]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // directed table
  typedef struct {
    req_item_t   r;
    bit          hand;
    answer_t     a;
  } row_t;

  row_t rows[$];

  function automatic req_item_t mk(logic [1:0] q, logic [1:0] f, logic [63:0] h, logic [63:0] l,
                                   logic [255:0] n, logic m);
    req_item_t r;
    r.req = q; r.fam = f; r.ahi = h; r.alo = l; r.name = n; r.mem = m;
    return r;
  endfunction

  function automatic void add_row(req_item_t r, bit hand, logic [1:0] st, logic mb);
    row_t w;
    w.r = r; w.hand = hand; w.a.status = st; w.a.member = mb;
    rows.push_back(w);
  endfunction

  initial begin
    logic [255:0] nm_a, nm_gap;
    logic [63:0]  ones;
    ones = '1;
    foreach (m_valid[i]) m_valid[i] = 1'b0;
    m_now = 0; m_ptr = 0; m_ttl = 12'd5; m_count = 9'd256;
    for (int i = 0; i < 8; i++) begin
      pool_ahi[i] = (i < 2) ? {64{i[0]}} : rand64();
      pool_alo[i] = (i < 2) ? {64{i[0]}} : rand64();
    end
    for (int i = 0; i < 4; i++)
      pool_name[i] = {rand64(), rand64(), rand64(), rand64()} >> (8 * $urandom_range(0, 31));
    nm_a = {224'd0, "tsil"};
    nm_gap = nm_a | (256'hAB << 64);  // bytes after the terminator must be ignored

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: empty table misses
    add_row(mk(REQ_LOOKUP, 2'd0, 64'd0, 64'h0a000001, nm_a, 1'b0), 1'b1, ST_MISS, 1'b0);
    add_row(mk(REQ_STORE, 2'd0, ones, {32'hFFFF_FFFF, 32'h0a000001}, nm_a, 1'b1), 1'b1,
            ST_DONE, 1'b0);
    add_row(mk(REQ_LOOKUP, 2'd0, 64'd0, 64'h0a000001, nm_gap, 1'b0), 1'b1, ST_HIT, 1'b1);
    add_row(mk(REQ_LOOKUP, 2'd1, 64'd0, 64'h0a000001, nm_a, 1'b0), 1'b1, ST_MISS, 1'b0);
    add_row(mk(REQ_STORE, 2'd1, ones, ones, '1, 1'b0), 1'b1, ST_DONE, 1'b0);
    add_row(mk(REQ_LOOKUP, 2'd1, ones, ones, {8'h00, {31{8'hFF}}}, 1'b0), 1'b1,
            ST_HIT, 1'b0);
    add_row(mk(REQ_LOOKUP, 2'd2, 64'd0, 64'd0, nm_a, 1'b0), 1'b1, ST_BAD, 1'b0);
    add_row(mk(REQ_STORE, 2'd3, ones, ones, '1, 1'b1), 1'b1, ST_BAD, 1'b0);
    add_row(mk(2'd3, 2'd0, 64'd0, 64'd0, 256'd0, 1'b0), 1'b1, ST_DONE, 1'b0);
    add_row(mk(REQ_STORE, 2'd0, 64'd0, 64'd0, 256'd0, 1'b1), 1'b1, ST_DONE, 1'b0);
    add_row(mk(REQ_LOOKUP, 2'd0, 64'd0, 64'd0, 256'd0, 1'b0), 1'b1, ST_HIT, 1'b1);
    for (int i = 0; i < 5; i++)
      add_row(mk(REQ_TICK, 2'd3, ones, ones, '1, 1'b1), 1'b1, ST_DONE, 1'b0);
    // all entries now expired
    add_row(mk(REQ_LOOKUP, 2'd0, 64'd0, 64'h0a000001, nm_a, 1'b0), 1'b1, ST_MISS, 1'b0);
    add_row(mk(REQ_LOOKUP, 2'd0, 64'd0, 64'd0, 256'd0, 1'b0), 1'b1, ST_MISS, 1'b0);
    foreach (rows[i]) begin
      idle_gap();
      send_item(rows[i].r, rows[i].hand, rows[i].a);
    end
    release_in();
    settle();

    // ttl zero: cache off
    write_reg(CFG_TTL, 12'd0);
    send_item(mk(REQ_STORE, 2'd0, 64'd0, 64'd5, nm_a, 1'b1), 1'b1, '{ST_DONE, 1'b0});
    send_item(mk(REQ_LOOKUP, 2'd0, 64'd0, 64'd5, nm_a, 1'b0), 1'b1, '{ST_MISS, 1'b0});
    release_in();
    settle();

    // phases over several settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      logic [11:0] t;
      logic [8:0]  c;
      int n;
      case (ph)
        0: begin t = 12'd1;    c = 9'd1;   end
        1: begin t = 12'd4095; c = 9'd4;   end
        2: begin t = 12'd3;    c = 9'd0;   end
        3: begin t = 12'd3600; c = 9'd256; end
        4: begin t = 12'd0;    c = 9'd511; end
        5: begin t = 12'd7;    c = 9'd300; end
        default: begin t = 12'($urandom_range(1, 20)); c = 9'($urandom_range(2, 16)); end
      endcase
      write_reg(CFG_TTL, t);
      write_reg(CFG_COUNT, {3'd0, c});
      n = (c == 0 || c > 9'd64) ? 150 : 250;
      fork
        if (ph == 1) begin
          // receiver stalls while the sender keeps offering items
          hold_off = 1'b1;
          repeat (1500) @(posedge clk);
          hold_off = 1'b0;
        end
        begin
          for (int k = 0; k < n; k++) begin
            idle_gap();
            send_item(random_item(), 1'b0, '{ST_DONE, 1'b0});
          end
          release_in();
        end
      join
      settle();
    end

    $display("sent %0d items, checked %0d answers, %0d hits", items_sent, answers_seen,
             hits_seen);
    $display("covered ttl 0/1/3600/4095, counts 0/1/256/300/511, stall and odd families");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("errors %0d, left over %0d", errors, pending_answers.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hdl/ttlmc_pkg.sv
hdl/ttlmc_datapath.sv
hdl/ttlmc_ctrl.sv
hdl/ttl_membership_cache_unit.sv
tb/sv/tb.sv
